[src/text_to_integer_parser_top_defines.svh]
// ----------------------------------------------------------------------------
// text_to_integer_parser_top_defines
// assertion macros shared by the checker of the text-to-integer parser
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_TOP_DEFINES_SVH
`define TEXT_TO_INTEGER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TTIP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttip check failed");

// next-cycle implication, quiet while reset is held
`define TTIP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttip check failed");

// state right after a reset cycle
`define TTIP_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("ttip check failed");

`endif

[src/ttip_pkg.sv]
// ----------------------------------------------------------------------------
// ttip_pkg
// types and constants shared by the text-to-integer parser modules
// ----------------------------------------------------------------------------
package ttip_pkg;

  // widths
  localparam int VALUE_BITS  = 64;
  localparam int OFFSET_BITS = 16;
  localparam int VALUE_W     = 64;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;

  // queue depths
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // bases
  localparam logic [RADIX_W-1:0] AUTO_RADIX = RADIX_W'(0);
  localparam logic [RADIX_W-1:0] DEC_BASE   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] OCT_BASE   = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] HEX_BASE   = RADIX_W'(16);

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd10;

  // input item
  typedef struct packed {
    logic [CHAR_W-1:0]  char_in;
    logic [RADIX_W-1:0] radix;
    logic               start_req;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFFSET_BITS-1:0]    stop_offset;
    logic                      no_digits;
  } out_item_t;

  // classified character handed from front to back
  typedef struct packed {
    logic               start_req;
    logic [RADIX_W-1:0] radix;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               is_nul;
    logic               is_minus;
    logic               is_x;
    logic               is_zero;
  } cmd_t;

  // parse phase
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

endpackage

[src/ttip_front.sv]
// ----------------------------------------------------------------------------
// ttip_front
// accepts input items and classifies each character for the back end
// ----------------------------------------------------------------------------
module ttip_front
  import ttip_pkg::*;
(
  input  logic     push,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     full,
  output logic     cmd_push,
  output cmd_t     cmd
);

  logic [CHAR_W-1:0] num_off;
  logic [CHAR_W-1:0] lo_off;
  logic [CHAR_W-1:0] up_off;

  // accept whenever the command queue has room
  assign full     = q_full;
  assign cmd_push = push && !q_full;

  assign num_off = in_item.char_in - CH_ZERO;
  assign lo_off  = in_item.char_in - CH_LO_A + LETTER_BIAS;
  assign up_off  = in_item.char_in - CH_UP_A + LETTER_BIAS;

  // digit value and special characters
  always_comb begin
    cmd.start_req = in_item.start_req;
    cmd.radix     = in_item.radix;
    cmd.is_digit  = 1'b1;
    cmd.digit     = num_off[DIGIT_W-1:0];
    if (in_item.char_in inside {[CH_LO_A:CH_LO_Z]}) begin
      cmd.digit = lo_off[DIGIT_W-1:0];
    end else if (in_item.char_in inside {[CH_UP_A:CH_UP_Z]}) begin
      cmd.digit = up_off[DIGIT_W-1:0];
    end else if (!(in_item.char_in inside {[CH_ZERO:CH_NINE]})) begin
      cmd.is_digit = 1'b0;
    end
    cmd.is_nul   = (in_item.char_in == CH_NUL);
    cmd.is_minus = (in_item.char_in == CH_MINUS);
    cmd.is_x     = (in_item.char_in inside {CH_LO_X, CH_UP_X});
    cmd.is_zero  = (in_item.char_in == CH_ZERO);
  end

endmodule

[src/ttip_cmd_queue.sv]
// ----------------------------------------------------------------------------
// ttip_cmd_queue
// short queue of classified characters between front and back
// ----------------------------------------------------------------------------
module ttip_cmd_queue
  import ttip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd_out
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign valid   = (cnt_r != '0);
  assign cmd_out = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

[src/ttip_back.sv]
// ----------------------------------------------------------------------------
// ttip_back
// parse state machine, multiply-accumulate and result queue
// ----------------------------------------------------------------------------
module ttip_back
  import ttip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  // parse state
  phase_t                   ph_r, ph_nxt;
  logic [RADIX_W-1:0]       base_r, base_nxt;
  logic                     neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic [OFFSET_BITS-1:0]   cnt_r, cnt_nxt;

  // effective values after start handling
  phase_t                   ph_e;
  logic [RADIX_W-1:0]       base_e;
  logic                     neg_e;
  logic [OFFSET_BITS-1:0]   cnt_e;
  logic [OFFSET_BITS-1:0]   cnt_adv;
  logic                     run;
  logic                     done;
  logic                     legal;

  logic [VALUE_BITS+RADIX_W-1:0] prod;
  logic [VALUE_BITS-1:0]    mac;
  logic [VALUE_BITS-1:0]    neg_acc;
  logic [VALUE_BITS-1:0]    res_acc;
  logic                     res_none;
  logic                     emit;
  out_item_t                res_item;

  // result queue
  out_item_t                out_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]     ocnt_r, ocnt_nxt;
  logic                     go;
  logic                     do_pop;

  // a character is taken whenever a result slot is free
  assign go      = cmd_valid && (ocnt_r != OUT_CNT_W'(OUT_DEPTH));
  assign cmd_pop = go;

  // multiply-accumulate and negation
  assign prod    = acc_r * base_e;
  assign mac     = prod[VALUE_BITS-1:0] + VALUE_BITS'(cmd.digit);
  assign neg_acc = '0 - acc_r;

  // parse step
  always_comb begin
    ph_nxt   = ph_r;
    base_nxt = base_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ph_e     = ph_r;
    base_e   = base_r;
    neg_e    = neg_r;
    cnt_e    = cnt_r;
    run      = 1'b0;
    done     = 1'b0;
    emit     = 1'b0;
    res_acc  = '0;
    res_none = 1'b0;
    if (go) begin
      if (cmd.start_req) begin
        neg_e   = 1'b0;
        cnt_e   = '0;
        neg_nxt = 1'b0;
        cnt_nxt = '0;
        acc_nxt = '0;
        if (cmd.radix == AUTO_RADIX && cmd.is_zero) begin
          // leading zero: wait for a possible x
          base_nxt = DEC_BASE;
          ph_nxt   = PH_ZERO;
          cnt_nxt  = OFFSET_BITS'(1);
        end else begin
          base_e = (cmd.radix == AUTO_RADIX) ? DEC_BASE : cmd.radix;
          ph_e   = PH_SKIP;
          run    = 1'b1;
        end
      end else begin
        run = (ph_r != PH_IDLE);
      end
    end
    cnt_adv = (cnt_e == '1) ? cnt_e : cnt_e + 1'b1;
    if (run) begin
      ph_nxt   = ph_e;
      base_nxt = base_e;
      // resolve the character after a leading zero
      if (ph_e == PH_ZERO) begin
        if (cmd.is_x) begin
          base_nxt = HEX_BASE;
          ph_nxt   = PH_SKIP;
          cnt_nxt  = cnt_adv;
          done     = 1'b1;
        end else begin
          base_e   = OCT_BASE;
          ph_e     = PH_DIGITS;
          base_nxt = OCT_BASE;
          ph_nxt   = PH_DIGITS;
        end
      end
    end
    legal = cmd.is_digit && (cmd.digit < base_e);
    if (run && !done) begin
      case (ph_e)
        PH_SKIP: begin
          if (legal) begin
            acc_nxt = VALUE_BITS'(cmd.digit);
            ph_nxt  = PH_DIGITS;
            cnt_nxt = cnt_adv;
          end else if (cmd.is_nul) begin
            emit     = 1'b1;
            res_none = 1'b1;
            ph_nxt   = PH_IDLE;
          end else begin
            if (cmd.is_minus) begin
              neg_nxt = 1'b1;
            end
            cnt_nxt = cnt_adv;
          end
        end
        PH_DIGITS: begin
          if (legal) begin
            acc_nxt = mac;
            cnt_nxt = cnt_adv;
          end else begin
            emit    = 1'b1;
            res_acc = neg_e ? neg_acc : acc_r;
            ph_nxt  = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // result item, the accumulator taken as a signed value of the same width
  always_comb begin
    res_item.value       = VALUE_W'(signed'(res_acc));
    res_item.stop_offset = cnt_e;
    res_item.no_digits   = res_none;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      base_r <= DEC_BASE;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      base_r <= base_nxt;
      neg_r  <= neg_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result queue control
  assign empty    = (ocnt_r == '0);
  assign do_pop   = pop && !empty;
  assign out_item = out_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    ocnt_nxt   = ocnt_r;
    if (emit) begin
      wr_ptr_nxt = (wr_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (emit && !do_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (do_pop && !emit) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      ocnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mem_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

[src/text_to_integer_parser_top.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser_top
// character-stream string-to-integer converter with queue interfaces
// ----------------------------------------------------------------------------
// One character is taken per cycle while the queues have room, with push/full
// on the input and empty/pop on the result side. An item with start_req set
// begins a new string (radix 0 auto-detects 0x hex, leading-0 octal, else
// decimal); the first illegal character after a digit, or a NUL before any
// digit, yields one result with the value and the offset of the stopping
// character. The ending item passes through the command queue register; its
// result is written into the result queue register and shows on out_item
// when nothing is waiting ahead of it. The rate is set by the back end's
// single multiply-add of the accumulator by the base, done once per character;
// two-entry command and result queues let each side stall on its own.
module text_to_integer_parser_top
  import ttip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_push;
  cmd_t cmd_front;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // classify incoming characters
  ttip_front u_front (
    .push     (push),
    .in_item  (in_item),
    .q_full   (q_full),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_front)
  );

  // decoupling queue
  ttip_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .cmd_in  (cmd_front),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .cmd_out (q_cmd)
  );

  // parse and emit results
  ttip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

[src/ttip_checker.sv]
// ----------------------------------------------------------------------------
// ttip_checker
// port-level checks for the text-to-integer parser
// ----------------------------------------------------------------------------
`include "text_to_integer_parser_top_defines.svh"

module ttip_checker
  import ttip_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // both queues come out of reset drained
  `TTIP_ASSERT_RST(a_reset_clean, empty && !full)

  // a waiting result holds until taken
  `TTIP_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(out_item))

  // a string that ended before any digit gives zero
  `TTIP_ASSERT_IMP(a_nodigit_zero, !empty && out_item.no_digits, out_item.value == '0)

  // a number always consumed at least one character
  `TTIP_ASSERT_IMP(a_digit_offset, !empty && !out_item.no_digits, out_item.stop_offset != '0)

endmodule

bind text_to_integer_parser_top ttip_checker u_ttip_checker (.*);
